// ----- rtl/core/qfu_pkg.sv -----
// ----------------------------------------------------------------------------
// qfu_pkg
// shared types and constants for the quick-find union-by-size unit
// ----------------------------------------------------------------------------
`default_nettype none

package qfu_pkg;

  // payload field widths
  localparam int NODE_W = 10;
  localparam int SIZE_W = 11;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_REP,
    ST_READ_SIZE,
    ST_DECIDE,
    ST_WALK_WR,
    ST_WALK_STEP,
    ST_LINK,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic latch_in;
    logic read_rep;
    logic read_size;
    logic decide;
    logic walk_write;
    logic walk_advance;
    logic link;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic joined;
    logic last_member;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/qfu_req_if.sv -----
// ----------------------------------------------------------------------------
// qfu_req_if
// request channel: two node indexes to join
// ----------------------------------------------------------------------------
`default_nettype none

interface qfu_req_if;
  import qfu_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;

  modport source (output valid, output first_node, output second_node, input ready);
  modport sink   (input valid, input first_node, input second_node, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/qfu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// qfu_rsp_if
// response channel: roots before the merge and the merged set
// ----------------------------------------------------------------------------
`default_nettype none

interface qfu_rsp_if;
  import qfu_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] first_root;
  logic [NODE_W-1:0] second_root;
  logic              already_joined;
  logic [NODE_W-1:0] merged_root;
  logic [SIZE_W-1:0] merged_size;

  modport source (output valid, output first_root, output second_root,
                  output already_joined, output merged_root, output merged_size,
                  input ready);
  modport sink   (input valid, input first_root, input second_root,
                  input already_joined, input merged_root, input merged_size,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/qfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// qfu_ctrl
// sequencer: clearing pass, root lookup, relabel walk, list append, result
// ----------------------------------------------------------------------------
`default_nettype none

module qfu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire qfu_pkg::status_t status,
  output qfu_pkg::cmd_t         cmd
);
  import qfu_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_READ_REP;
      end
      ST_READ_REP:  state_next = ST_READ_SIZE;
      ST_READ_SIZE: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.joined) state_next = ST_FINISH;
        else state_next = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        if (status.last_member) state_next = ST_LINK;
        else state_next = ST_WALK_STEP;
      end
      ST_WALK_STEP: state_next = ST_WALK_WR;
      ST_LINK:      state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_CLEAR:     cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.latch_in = req_valid;
      end
      ST_READ_REP:  cmd.read_rep = 1'b1;
      ST_READ_SIZE: cmd.read_size = 1'b1;
      ST_DECIDE:    cmd.decide = 1'b1;
      ST_WALK_WR:   cmd.walk_write = 1'b1;
      ST_WALK_STEP: cmd.walk_advance = 1'b1;
      ST_LINK:      cmd.link = 1'b1;
      ST_FINISH:    cmd.load_out = status.out_free;
      default: begin
        cmd       = '0;
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/qfu_dp.sv -----
// ----------------------------------------------------------------------------
// qfu_dp
// datapath: the four tables, lookup registers, walk pointer and result stage
// ----------------------------------------------------------------------------
`default_nettype none

module qfu_dp #(
  parameter int NODES = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire qfu_pkg::cmd_t              cmd,
  output qfu_pkg::status_t                status,
  input  wire logic [qfu_pkg::NODE_W-1:0] first_node,
  input  wire logic [qfu_pkg::NODE_W-1:0] second_node,
  qfu_rsp_if.source                       rsp
);
  import qfu_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);

  // tables
  logic [NW-1:0] rep_mem  [NODES];
  logic [SW-1:0] size_mem [NODES];
  logic [NW-1:0] next_mem [NODES];
  logic [NW-1:0] tail_mem [NODES];

  // clearing pass
  logic [NW-1:0] clr_idx;

  // request and lookup registers
  logic [NW-1:0] a_q, b_q;
  logic [NW-1:0] ra_q, rb_q;
  logic [SW-1:0] sa_q, sb_q;
  logic [NW-1:0] ta_q, tb_q;
  logic [NW-1:0] nm_q;

  // merge registers
  logic [NW-1:0] keep_q, gone_q, walk_q;
  logic [NW-1:0] tail_keep_q, tail_gone_q;
  logic [SW-1:0] size_keep_q, size_gone_q;
  logic [SW-1:0] count_q;
  logic [SW-1:0] msize_q;
  logic [NW-1:0] mroot_q;

  // output stage
  logic              out_valid;
  logic [NODE_W-1:0] o_first_root, o_second_root, o_merged_root;
  logic              o_joined;
  logic [SIZE_W-1:0] o_merged_size;

  // input clamp to the last node
  logic [NW+NODE_W-1:0] a_ext, b_ext;
  logic [NW-1:0]        a_idx, b_idx;

  assign a_ext = {{NW{1'b0}}, first_node};
  assign b_ext = {{NW{1'b0}}, second_node};

  always_comb begin
    if (32'(first_node) >= 32'(NODES)) a_idx = NW'(NODES - 1);
    else a_idx = a_ext[NW-1:0];
    if (32'(second_node) >= 32'(NODES)) b_idx = NW'(NODES - 1);
    else b_idx = b_ext[NW-1:0];
  end

  logic joined;
  assign joined = (ra_q == rb_q);

  // table write ports
  logic          rep_we,  size_we,  next_we,  tail_we;
  logic [NW-1:0] rep_wa,  size_wa,  next_wa,  tail_wa;
  logic [NW-1:0] rep_wd,  next_wd,  tail_wd;
  logic [SW-1:0] size_wd;

  always_comb begin
    rep_we  = cmd.clear_wr | cmd.walk_write;
    rep_wa  = cmd.clear_wr ? clr_idx : walk_q;
    rep_wd  = cmd.clear_wr ? clr_idx : keep_q;
    size_we = cmd.clear_wr | cmd.link;
    size_wa = cmd.clear_wr ? clr_idx : keep_q;
    size_wd = cmd.clear_wr ? SW'(1) : SW'(size_keep_q + size_gone_q);
    next_we = cmd.clear_wr | cmd.link;
    next_wa = cmd.clear_wr ? clr_idx : tail_keep_q;
    next_wd = cmd.clear_wr ? clr_idx : gone_q;
    tail_we = cmd.clear_wr | cmd.link;
    tail_wa = cmd.clear_wr ? clr_idx : keep_q;
    tail_wd = cmd.clear_wr ? clr_idx : tail_gone_q;
  end

  always_ff @(posedge clk) begin
    if (rep_we) rep_mem[rep_wa] <= rep_wd;
    if (cmd.read_rep) begin
      ra_q <= rep_mem[a_q];
      rb_q <= rep_mem[b_q];
    end
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (cmd.read_size) begin
      sa_q <= size_mem[ra_q];
      sb_q <= size_mem[rb_q];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd.walk_write) nm_q <= next_mem[walk_q];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (cmd.read_size) begin
      ta_q <= tail_mem[ra_q];
      tb_q <= tail_mem[rb_q];
    end
  end

  // clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_wr) begin
      clr_idx <= NW'(clr_idx + 1'b1);
    end
  end

  // request, merge decision and walk
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_q <= a_idx;
      b_q <= b_idx;
    end
    if (cmd.decide) begin
      if (sa_q < sb_q) begin
        keep_q      <= rb_q;
        gone_q      <= ra_q;
        walk_q      <= ra_q;
        count_q     <= sa_q;
        tail_keep_q <= tb_q;
        tail_gone_q <= ta_q;
        size_keep_q <= sb_q;
        size_gone_q <= sa_q;
      end else begin
        keep_q      <= ra_q;
        gone_q      <= rb_q;
        walk_q      <= rb_q;
        count_q     <= sb_q;
        tail_keep_q <= ta_q;
        tail_gone_q <= tb_q;
        size_keep_q <= sa_q;
        size_gone_q <= sb_q;
      end
      // same-set answer
      mroot_q <= ra_q;
      msize_q <= sa_q;
    end
    if (cmd.walk_advance) begin
      walk_q  <= nm_q;
      count_q <= SW'(count_q - 1'b1);
    end
    if (cmd.link) begin
      mroot_q <= keep_q;
      msize_q <= SW'(size_keep_q + size_gone_q);
    end
  end

  // result stage, fields truncated to the port widths
  logic [NW+NODE_W-1:0] fr_ext, sr_ext, mr_ext;
  logic [SW+SIZE_W-1:0] ms_ext;

  assign fr_ext = {{NODE_W{1'b0}}, ra_q};
  assign sr_ext = {{NODE_W{1'b0}}, rb_q};
  assign mr_ext = {{NODE_W{1'b0}}, mroot_q};
  assign ms_ext = {{SIZE_W{1'b0}}, msize_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_first_root  <= fr_ext[NODE_W-1:0];
      o_second_root <= sr_ext[NODE_W-1:0];
      o_joined      <= joined;
      o_merged_root <= mr_ext[NODE_W-1:0];
      o_merged_size <= ms_ext[SIZE_W-1:0];
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.first_root     = o_first_root;
  assign rsp.second_root    = o_second_root;
  assign rsp.already_joined = o_joined;
  assign rsp.merged_root    = o_merged_root;
  assign rsp.merged_size    = o_merged_size;

  assign status.clear_last  = (32'(clr_idx) == 32'(NODES - 1));
  assign status.joined      = joined;
  assign status.last_member = (count_q == SW'(1));
  assign status.out_free    = ~out_valid | rsp.ready;

endmodule

`default_nettype wire

// ----- rtl/core/quick_find_union_by_size_unit.sv -----
// ----------------------------------------------------------------------------
// quick_find_union_by_size_unit
// quick-find disjoint-set table with union by size
// ----------------------------------------------------------------------------
// usage:
//   req carries first_node / second_node; a beat asks to join their sets
//   (both equal makes it a plain find). rsp returns one beat per request:
//   both roots before the merge, already_joined, merged root and size.
// reset:
//   rst is synchronous. afterwards a clearing pass writes every table
//   entry, one node per cycle, with req.ready held low.
// sequencing:
//   one request at a time. a same-set request runs the root read, the size
//   read and the decision before its result is loaded; a real merge also
//   walks the absorbed (smaller) set, where each member costs one relabel
//   write plus one registered read of the member-list memory to find the
//   next member. the next request is accepted in the cycle after the result
//   is loaded.
// stalls:
//   rsp is a registered stage; while it waits for rsp.ready the unit
//   still takes and processes the next request up to the point of
//   loading its own result, then waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module quick_find_union_by_size_unit #(
  parameter int NODES = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  qfu_req_if.sink   req,
  qfu_rsp_if.source rsp
);
  import qfu_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  qfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // tables and merge datapath
  qfu_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .first_node  (req.first_node),
    .second_node (req.second_node),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

// ----- sim/quick_find_union_by_size_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quick_find_union_by_size_unit_tb
// self-checking bench for the quick-find union-by-size unit: a bursty driver
// feeds join requests, a stalling monitor checks each response beat against
// a shadow disjoint-set table kept in the bench
// ----------------------------------------------------------------------------
module quick_find_union_by_size_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qfu_pkg::NODE_W;
  import qfu_pkg::SIZE_W;

  localparam int NODE_COUNT   = 1024;
  localparam int RANDOM_BEATS = 1950;
  // watchdog limit for the whole run, in ns
  localparam int RUN_LIMIT_NS = 6_000_000;

  // one join request as it travels on the req channel
  typedef struct packed {
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
  } join_req_t;

  // one response beat as it should appear on the rsp channel
  typedef struct packed {
    logic [NODE_W-1:0] first_root;
    logic [NODE_W-1:0] second_root;
    logic              already_joined;
    logic [NODE_W-1:0] merged_root;
    logic [SIZE_W-1:0] merged_size;
  } join_rsp_t;

  // receiver behaviors, switched at random by the monitor
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_BURSTY
  } sink_mode_t;

  logic clk;
  logic rst;

  qfu_req_if req_ch ();
  qfu_rsp_if rsp_ch ();

  quick_find_union_by_size_unit #(
    .NODES(NODE_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // --------------------------------------------------------------------------
  // shadow disjoint-set table
  // --------------------------------------------------------------------------
  // root_of holds each node's representative; set_count is only meaningful
  // at a root; member lists are chained through next_in_set, headed by the
  // root, with last_in_set giving the list end at the root
  logic [NODE_W-1:0] root_of     [NODE_COUNT];
  logic [SIZE_W-1:0] set_count   [NODE_COUNT];
  logic [NODE_W-1:0] next_in_set [NODE_COUNT];
  logic [NODE_W-1:0] last_in_set [NODE_COUNT];

  join_req_t pending_q[$];   // requests not yet put on the wire
  join_rsp_t merge_q[$];     // predicted responses, oldest first
  int        fail_count;

  // joins the sets of both nodes and returns what the unit must report
  function automatic join_rsp_t join_sets(input join_req_t r);
    int                a;
    int                b;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    logic [NODE_W-1:0] keep;
    logic [NODE_W-1:0] gone;
    logic [NODE_W-1:0] walk;
    join_rsp_t         res;
    // indexes past the table saturate to the last node
    a = (int'(r.first_node) >= NODE_COUNT) ? NODE_COUNT - 1 : int'(r.first_node);
    b = (int'(r.second_node) >= NODE_COUNT) ? NODE_COUNT - 1 : int'(r.second_node);
    ra = root_of[a];
    rb = root_of[b];
    res.first_root     = ra;
    res.second_root    = rb;
    res.already_joined = (ra == rb);
    if (ra == rb) begin
      // same set: nothing moves
      res.merged_root = ra;
      res.merged_size = set_count[ra];
      return res;
    end
    // smaller set is absorbed, first root wins a tie
    keep = ra;
    gone = rb;
    if (set_count[ra] < set_count[rb]) begin
      keep = rb;
      gone = ra;
    end
    walk = gone;
    for (int k = 0; k < int'(set_count[gone]) && k < NODE_COUNT; k++) begin
      root_of[walk] = keep;
      walk = next_in_set[walk];
    end
    // splice absorbed list after the survivor's tail; stale entries of the
    // absorbed root stay as they are
    next_in_set[last_in_set[keep]] = gone;
    last_in_set[keep] = last_in_set[gone];
    set_count[keep] = set_count[keep] + set_count[gone];
    res.merged_root = keep;
    res.merged_size = set_count[keep];
    return res;
  endfunction

  function automatic void queue_join(input int a, input int b);
    join_req_t r;
    r.first_node  = NODE_W'(a);
    r.second_node = NODE_W'(b);
    pending_q = {pending_q, r};
  endfunction

  function automatic void check_field(input string name, input logic [SIZE_W-1:0] want,
                                      input logic [SIZE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------
  // bursts of 1..24 beats, then an idle gap of random length; a zero gap just
  // runs the next burst back to back. a held beat is never touched until
  // the unit takes it
  join_req_t on_wire;
  int        burst_left;
  int        gap_left;
  logic      load_beat;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(req_ch.valid && !req_ch.ready)) begin
      // beat taken at this edge: its prediction is queued right away, in
      // acceptance order
      if (req_ch.valid && req_ch.ready)
        merge_q = {merge_q, join_sets(on_wire)};
      load_beat = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        load_beat = 1'b1;
        if (burst_left == 0)
          burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (load_beat) begin
        on_wire = pending_q.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.first_node  <= on_wire.first_node;
        req_ch.second_node <= on_wire.second_node;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // response monitor and receiver stalls
  // --------------------------------------------------------------------------
  sink_mode_t sink_mode;
  int         mode_left;
  int         hold_left;
  logic       ready_level;
  join_rsp_t  want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      mode_left   = 0;
      hold_left   = 0;
      ready_level = 1'b1;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (merge_q.size() == 0) begin
          $error("response beat with no request outstanding");
          fail_count++;
        end else begin
          want = merge_q.pop_front();
          check_field("first_root", SIZE_W'(want.first_root), SIZE_W'(rsp_ch.first_root));
          check_field("second_root", SIZE_W'(want.second_root), SIZE_W'(rsp_ch.second_root));
          check_field("already_joined", SIZE_W'(want.already_joined),
                      SIZE_W'(rsp_ch.already_joined));
          check_field("merged_root", SIZE_W'(want.merged_root), SIZE_W'(rsp_ch.merged_root));
          check_field("merged_size", want.merged_size, rsp_ch.merged_size);
        end
      end
      // pick a new receiver behavior now and then
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (sink_mode)
        SINK_OPEN: begin
          rsp_ch.ready <= 1'b1;
        end
        SINK_RANDOM: begin
          rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          // long stalls and long open runs, alternating
          if (hold_left == 0) begin
            ready_level = ~ready_level;
            hold_left   = ready_level ? $urandom_range(1, 8) : $urandom_range(1, 20);
          end
          hold_left--;
          rsp_ch.ready <= ready_level;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int span;
    int base;
    int pick;
    int a;
    int b;

    // everything known from time zero
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.first_node  = '0;
    req_ch.second_node = '0;
    rsp_ch.ready       = 1'b0;
    fail_count         = 0;

    // shadow table starts as all singletons
    for (int i = 0; i < NODE_COUNT; i++) begin
      root_of[i]     = NODE_W'(i);
      set_count[i]   = SIZE_W'(1);
      next_in_set[i] = NODE_W'(i);
      last_in_set[i] = NODE_W'(i);
    end

    // directed part
    queue_join(0, 0);            // find on the lowest node
    queue_join(1023, 1023);      // find on the highest node
    queue_join(0, 1023);         // tie: first root survives
    queue_join(1023, 0);         // already one set
    queue_join(5, 6);
    queue_join(7, 5);            // first set smaller, second root survives
    queue_join(0, 6);            // two-member set absorbed into three
    queue_join(1023, 1023);      // find after relabel
    queue_join(1023, 7);         // same set via non-root members
    queue_join(512, 511);        // single-bit vs all-but-top patterns
    queue_join(341, 682);        // alternating bit patterns
    queue_join(511, 682);        // tie between two pairs, via members
    queue_join(1023, 512);       // five absorbs four
    queue_join(200, 201);
    queue_join(202, 203);
    queue_join(200, 202);
    queue_join(203, 0);          // smaller first set, absorbed into the big one
    queue_join(682, 682);        // find deep inside a merged set
    queue_join(1, 1022);

    // random part: joins inside a moving window so sets grow and large relabel
    // walks happen, as many spread-out joins, and some plain finds
    span = 8;
    base = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) begin
        span = 8 << (2 * $urandom_range(0, 2));
        base = $urandom_range(0, NODE_COUNT - span);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        a = base + $urandom_range(0, span - 1);
        b = base + $urandom_range(0, span - 1);
      end else if (pick < 90) begin
        a = $urandom_range(0, NODE_COUNT - 1);
        b = $urandom_range(0, NODE_COUNT - 1);
      end else begin
        a = $urandom_range(0, NODE_COUNT - 1);
        b = a;
      end
      queue_join(a, b);
    end

    // single reset; the unit then clears its tables with req.ready low
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // drain: all beats sent and every response back
    while (pending_q.size() != 0 || req_ch.valid || merge_q.size() != 0)
      @(posedge clk);
    // quiet period to catch stray response beats
    repeat (64) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #RUN_LIMIT_NS;
    $display("FAIL");
    $finish;
  end

endmodule
